@@ src/sbc_pkg.sv @@
package sbc_pkg;

    localparam int CFG_ADDR_W = 3;

    typedef logic [CFG_ADDR_W-1:0] t_cfg_addr;
    typedef logic [1:0]            t_side;

    localparam t_cfg_addr CFG_BOX_LEFT   = 3'd0;
    localparam t_cfg_addr CFG_BOX_RIGHT  = 3'd1;
    localparam t_cfg_addr CFG_BOX_BOTTOM = 3'd2;
    localparam t_cfg_addr CFG_BOX_TOP    = 3'd3;
    localparam t_cfg_addr CFG_TOLERANCE  = 3'd4;

    localparam t_side SIDE_LEFT   = 2'd0;
    localparam t_side SIDE_RIGHT  = 2'd1;
    localparam t_side SIDE_BOTTOM = 2'd2;
    localparam t_side SIDE_TOP    = 2'd3;

    localparam int TOL_BITS = 16;

endpackage

@@ src/sbc_seg_if.sv @@
interface sbc_seg_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;

    modport source (output valid, start_x, start_y, end_x, end_y, input ready);
    modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

@@ src/sbc_res_if.sv @@
interface sbc_res_if #(parameter int COORD_BITS = 32);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   crossing_count;
    sbc_pkg::t_side               near_side;
    logic signed [COORD_BITS-1:0] near_x;
    logic signed [COORD_BITS-1:0] near_y;
    sbc_pkg::t_side               far_side;
    logic signed [COORD_BITS-1:0] far_x;
    logic signed [COORD_BITS-1:0] far_y;

    modport source (output valid, crossing_count, near_side, near_x, near_y,
                    far_side, far_x, far_y, input ready);
    modport sink   (input valid, crossing_count, near_side, near_x, near_y,
                    far_side, far_x, far_y, output ready);
endinterface

@@ src/sbc_cfg_if.sv @@
interface sbc_cfg_if #(parameter int COORD_BITS = 32);
    logic                    valid;
    logic                    ready;
    sbc_pkg::t_cfg_addr      addr;
    logic [COORD_BITS-1:0]   data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

@@ src/sbc_side.sv @@
module sbc_side #(
    parameter int COORD_BITS    = 32,
    parameter int FRACTION_BITS = 16,
    parameter bit BELOW         = 1'b1
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic signed [COORD_BITS-1:0] i_oa,
    input  logic signed [COORD_BITS-1:0] i_ea,
    input  logic signed [COORD_BITS-1:0] i_ob,
    input  logic signed [COORD_BITS-1:0] i_eb,
    input  logic signed [COORD_BITS-1:0] i_side,
    input  logic signed [COORD_BITS-1:0] i_lo,
    input  logic signed [COORD_BITS-1:0] i_hi,
    input  logic [sbc_pkg::TOL_BITS-1:0] i_eps,
    output logic                         o_ok,
    output logic [FRACTION_BITS-1:0]     o_t,
    output logic [COORD_BITS-1:0]        o_pb
);
    localparam int C  = COORD_BITS;
    localparam int F  = FRACTION_BITS;
    localparam int W  = C + 2;
    localparam int TW = ((F > sbc_pkg::TOL_BITS) ? F : sbc_pkg::TOL_BITS) + 2;
    localparam int PW = F + C + 1;

    // setup stage
    logic signed [W-1:0] oa_w, ea_w, ob_w, eb_w, side_w, eps_w, num, den, db;
    logic [C:0]          un, ud;
    logic                pre, n_ok0;

    assign oa_w   = {{2{i_oa[C-1]}}, i_oa};
    assign ea_w   = {{2{i_ea[C-1]}}, i_ea};
    assign ob_w   = {{2{i_ob[C-1]}}, i_ob};
    assign eb_w   = {{2{i_eb[C-1]}}, i_eb};
    assign side_w = {{2{i_side[C-1]}}, i_side};
    assign eps_w  = {{(W-sbc_pkg::TOL_BITS){1'b0}}, i_eps};
    assign num    = side_w - oa_w;
    assign den    = ea_w - oa_w;
    assign db     = eb_w - ob_w;
    assign un     = num[W-1] ? (C+1)'(0) - num[C:0] : num[C:0];
    assign ud     = den[W-1] ? (C+1)'(0) - den[C:0] : den[C:0];

    always_comb begin
        if (BELOW) begin
            pre = (oa_w < side_w - eps_w) || (ea_w < side_w - eps_w);
        end else begin
            pre = (oa_w > side_w + eps_w) || (ea_w > side_w + eps_w);
        end
        n_ok0 = pre && (den != '0) && (num != '0) && (num[W-1] == den[W-1]) && (un < ud);
    end

    logic                r_ok  [F+1];
    logic [C:0]          r_rem [F+1];
    logic [C:0]          r_ud  [F+1];
    logic [F-1:0]        r_quo [F+1];
    logic [C-1:0]        r_ob  [F+1];
    logic                r_dbn [F+1];
    logic [C:0]          r_dbm [F+1];

    // restoring division, one quotient bit per stage
    logic [C+1:0]        n_r2  [F];
    logic [F-1:0]        n_bit;

    always_comb begin
        for (int k = 0; k < F; k++) begin
            n_r2[k]  = {r_rem[k], 1'b0};
            n_bit[k] = n_r2[k] >= {1'b0, r_ud[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok[0]  <= n_ok0;
            r_rem[0] <= un;
            r_ud[0]  <= ud;
            r_quo[0] <= '0;
            r_ob[0]  <= i_ob;
            r_dbn[0] <= db[W-1];
            r_dbm[0] <= db[W-1] ? (C+1)'(0) - db[C:0] : db[C:0];
            for (int k = 0; k < F; k++) begin
                r_ok[k+1]  <= r_ok[k];
                r_rem[k+1] <= n_bit[k] ? (C+1)'(n_r2[k] - {1'b0, r_ud[k]}) : n_r2[k][C:0];
                r_ud[k+1]  <= r_ud[k];
                r_quo[k+1] <= {r_quo[k][F-2:0], n_bit[k]};
                r_ob[k+1]  <= r_ob[k];
                r_dbn[k+1] <= r_dbn[k];
                r_dbm[k+1] <= r_dbm[k];
            end
        end
    end

    // t window check and offset product
    logic signed [TW-1:0] t_w, teps_w, tone_w;
    logic                 n_tok;

    assign t_w    = TW'(r_quo[F]);
    assign teps_w = TW'(i_eps);
    assign tone_w = TW'(1) <<< F;
    assign n_tok  = r_ok[F] && (t_w > teps_w) && (t_w < tone_w - teps_w);

    logic          r_ok_m, r_dbn_m;
    logic [F-1:0]  r_t_m;
    logic [PW-1:0] r_prod;
    logic [C-1:0]  r_ob_m;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok_m  <= n_tok;
            r_t_m   <= r_quo[F];
            r_prod  <= PW'(r_quo[F]) * PW'(r_dbm[F]);
            r_ob_m  <= r_ob[F];
            r_dbn_m <= r_dbn[F];
        end
    end

    // crossing point and span check
    logic signed [W-1:0] off_w, pb_w, lo_w, hi_w, obm_w;
    logic                n_pok;

    assign off_w = {1'b0, r_prod[PW-1:F]};
    assign obm_w = {{2{r_ob_m[C-1]}}, r_ob_m};
    assign pb_w  = r_dbn_m ? obm_w - off_w : obm_w + off_w;
    assign lo_w  = {{2{i_lo[C-1]}}, i_lo};
    assign hi_w  = {{2{i_hi[C-1]}}, i_hi};
    assign n_pok = r_ok_m && (pb_w >= lo_w - eps_w) && (pb_w <= hi_w + eps_w);

    logic               r_ok_p;
    logic [F-1:0]       r_t_p;
    logic [C-1:0]       r_pb_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ok_p <= n_pok;
            r_t_p  <= r_t_m;
            r_pb_p <= pb_w[C-1:0];
        end
    end

    assign o_ok = r_ok_p;
    assign o_t  = r_t_p;
    assign o_pb = r_pb_p;

endmodule

@@ src/segment_box_crossings_top.sv @@
// Segment versus box border crossings.
// i_seg carries one segment (start and end point, signed fixed point) per
// transaction; o_res returns one result per segment, in order: the count of
// border crossings (0 to 2) and the nearer and farther crossing with its side.
// i_cfg writes the box edges and the tolerance; write it only while no
// segment is in flight. i_cfg.ready is always high.
// The pipeline has one setup stage, one stage per quotient bit of the
// restoring divider that forms t, one multiply stage, one point and span
// check stage, and the output register that orders the crossings.
// Throughput is one segment per cycle while o_res is not stalled.
// A stall on o_res freezes the whole pipeline and drops i_seg.ready, so no
// transaction is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and loads the box
// with left 0, right 1.0, bottom 0, top 1.0 and a tolerance of one LSB.
module segment_box_crossings_top #(
    parameter int COORD_BITS    = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    sbc_seg_if.sink   i_seg,
    sbc_cfg_if.sink   i_cfg,
    sbc_res_if.source o_res
);
    localparam int C = COORD_BITS;
    localparam int F = FRACTION_BITS;
    localparam int D = F + 4;
    localparam logic [C-1:0] ONE = C'(1) << F;

    logic signed [C-1:0]             r_left, r_right, r_bottom, r_top;
    logic [sbc_pkg::TOL_BITS-1:0]    r_tol;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_right  <= ONE;
            r_bottom <= '0;
            r_top    <= ONE;
            r_tol    <= sbc_pkg::TOL_BITS'(1);
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                sbc_pkg::CFG_BOX_LEFT:   r_left   <= i_cfg.data;
                sbc_pkg::CFG_BOX_RIGHT:  r_right  <= i_cfg.data;
                sbc_pkg::CFG_BOX_BOTTOM: r_bottom <= i_cfg.data;
                sbc_pkg::CFG_BOX_TOP:    r_top    <= i_cfg.data;
                sbc_pkg::CFG_TOLERANCE:  r_tol    <= i_cfg.data[sbc_pkg::TOL_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic         en;
    logic [D-1:0] r_vld;

    assign en          = !r_vld[D-1] || o_res.ready;
    assign i_seg.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[D-2:0], i_seg.valid};
        end
    end

    logic         ok   [4];
    logic [F-1:0] tt   [4];
    logic [C-1:0] pb   [4];

    sbc_side #(.COORD_BITS(C), .FRACTION_BITS(F), .BELOW(1'b1)) u_left (
        .i_clk(i_clk), .i_en(en),
        .i_oa(i_seg.start_x), .i_ea(i_seg.end_x),
        .i_ob(i_seg.start_y), .i_eb(i_seg.end_y),
        .i_side(r_left), .i_lo(r_bottom), .i_hi(r_top), .i_eps(r_tol),
        .o_ok(ok[0]), .o_t(tt[0]), .o_pb(pb[0])
    );
    sbc_side #(.COORD_BITS(C), .FRACTION_BITS(F), .BELOW(1'b0)) u_right (
        .i_clk(i_clk), .i_en(en),
        .i_oa(i_seg.start_x), .i_ea(i_seg.end_x),
        .i_ob(i_seg.start_y), .i_eb(i_seg.end_y),
        .i_side(r_right), .i_lo(r_bottom), .i_hi(r_top), .i_eps(r_tol),
        .o_ok(ok[1]), .o_t(tt[1]), .o_pb(pb[1])
    );
    sbc_side #(.COORD_BITS(C), .FRACTION_BITS(F), .BELOW(1'b1)) u_bottom (
        .i_clk(i_clk), .i_en(en),
        .i_oa(i_seg.start_y), .i_ea(i_seg.end_y),
        .i_ob(i_seg.start_x), .i_eb(i_seg.end_x),
        .i_side(r_bottom), .i_lo(r_left), .i_hi(r_right), .i_eps(r_tol),
        .o_ok(ok[2]), .o_t(tt[2]), .o_pb(pb[2])
    );
    sbc_side #(.COORD_BITS(C), .FRACTION_BITS(F), .BELOW(1'b0)) u_top (
        .i_clk(i_clk), .i_en(en),
        .i_oa(i_seg.start_y), .i_ea(i_seg.end_y),
        .i_ob(i_seg.start_x), .i_eb(i_seg.end_x),
        .i_side(r_top), .i_lo(r_left), .i_hi(r_right), .i_eps(r_tol),
        .o_ok(ok[3]), .o_t(tt[3]), .o_pb(pb[3])
    );

    // collect crossings in test order, then order by t
    logic [1:0]     cnt;
    logic [F-1:0]   st   [2];
    sbc_pkg::t_side ss   [2];
    logic [C-1:0]   sx   [2];
    logic [C-1:0]   sy   [2];
    logic           swap;

    always_comb begin
        cnt = '0;
        for (int j = 0; j < 2; j++) begin
            st[j] = '0;
            ss[j] = sbc_pkg::SIDE_LEFT;
            sx[j] = '0;
            sy[j] = '0;
        end
        if (ok[0]) begin
            st[cnt[0]] = tt[0]; ss[cnt[0]] = sbc_pkg::SIDE_LEFT;
            sx[cnt[0]] = r_left; sy[cnt[0]] = pb[0];
            cnt = cnt + 2'd1;
        end
        if (ok[1]) begin
            st[cnt[0]] = tt[1]; ss[cnt[0]] = sbc_pkg::SIDE_RIGHT;
            sx[cnt[0]] = r_right; sy[cnt[0]] = pb[1];
            cnt = cnt + 2'd1;
        end
        if (cnt < 2'd2 && ok[2]) begin
            st[cnt[0]] = tt[2]; ss[cnt[0]] = sbc_pkg::SIDE_BOTTOM;
            sx[cnt[0]] = pb[2]; sy[cnt[0]] = r_bottom;
            cnt = cnt + 2'd1;
        end
        if (cnt < 2'd2 && ok[3]) begin
            st[cnt[0]] = tt[3]; ss[cnt[0]] = sbc_pkg::SIDE_TOP;
            sx[cnt[0]] = pb[3]; sy[cnt[0]] = r_top;
            cnt = cnt + 2'd1;
        end
        swap = (cnt == 2'd2) && (st[0] > st[1]);
    end

    logic [1:0]     r_cnt;
    sbc_pkg::t_side r_ns, r_fs;
    logic [C-1:0]   r_nx, r_ny, r_fx, r_fy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cnt <= cnt;
            r_ns  <= ss[swap];
            r_nx  <= sx[swap];
            r_ny  <= sy[swap];
            r_fs  <= ss[!swap];
            r_fx  <= sx[!swap];
            r_fy  <= sy[!swap];
        end
    end

    assign o_res.valid          = r_vld[D-1];
    assign o_res.crossing_count = r_cnt;
    assign o_res.near_side      = r_ns;
    assign o_res.near_x         = r_nx;
    assign o_res.near_y         = r_ny;
    assign o_res.far_side       = r_fs;
    assign o_res.far_x          = r_fx;
    assign o_res.far_y          = r_fy;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [1:0]         count;
        sbc_pkg::t_side     near_side;
        logic signed [31:0] near_x;
        logic signed [31:0] near_y;
        sbc_pkg::t_side     far_side;
        logic signed [31:0] far_x;
        logic signed [31:0] far_y;
    } t_crossing;

    localparam longint T_ONE = 64'sd65536;
    localparam int STALL_LIMIT = 2000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   n_errors = 0;
    bit   calm = 1'b0;
    longint box_l = 0, box_r = T_ONE, box_b = 0, box_t = T_ONE, tol = 1;

    always #5 i_clk = ~i_clk;

    sbc_seg_if seg_if ();
    sbc_cfg_if cfg_if ();
    sbc_res_if res_if ();

    segment_box_crossings_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_seg  (seg_if),
        .i_cfg  (cfg_if),
        .o_res  (res_if)
    );

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        n_errors++;
    endtask

    // One side test; returns 1 with t and the along-side coordinate on a hit.
    function automatic bit side_hit(input longint oa, ea, ob, eb, side, input bit below,
                                    input longint lo, hi,
                                    output longint t_o, output longint pb);
        longint num, den, db, un, ud, q, r, off;
        t_o = 0;
        pb = 0;
        if (below) begin
            if (!(oa < side - tol || ea < side - tol)) return 0;
        end else begin
            if (!(oa > side + tol || ea > side + tol)) return 0;
        end
        den = ea - oa;
        if (den == 0) return 0;
        num = side - oa;
        if (num == 0 || ((num < 0) != (den < 0))) return 0;
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        if (un >= ud) return 0;
        q = 0;
        r = un;
        for (int k = 0; k < 16; k++) begin
            r = r <<< 1;
            q = q <<< 1;
            if (r >= ud) begin
                r -= ud;
                q |= 1;
            end
        end
        if (!(q > tol && q < T_ONE - tol)) return 0;
        db = eb - ob;
        off = (q * (db < 0 ? -db : db)) >>> 16;
        pb = db < 0 ? ob - off : ob + off;
        if (!(pb >= lo - tol && pb <= hi + tol)) return 0;
        t_o = q;
        return 1;
    endfunction

    function automatic t_crossing predict_crossings(input logic signed [31:0] sx, sy, ex, ey);
        longint ts[2], xs[2], ys[2], t, p;
        sbc_pkg::t_side sd[2];
        int n, a, b;
        t_crossing res;
        n = 0;
        ts = '{0, 0};
        xs = '{0, 0};
        ys = '{0, 0};
        sd = '{sbc_pkg::SIDE_LEFT, sbc_pkg::SIDE_LEFT};
        if (side_hit(sx, ex, sy, ey, box_l, 1, box_b, box_t, t, p)) begin
            ts[n] = t; sd[n] = sbc_pkg::SIDE_LEFT; xs[n] = box_l; ys[n] = p; n++;
        end
        if (side_hit(sx, ex, sy, ey, box_r, 0, box_b, box_t, t, p)) begin
            ts[n] = t; sd[n] = sbc_pkg::SIDE_RIGHT; xs[n] = box_r; ys[n] = p; n++;
        end
        if (n < 2 && side_hit(sy, ey, sx, ex, box_b, 1, box_l, box_r, t, p)) begin
            ts[n] = t; sd[n] = sbc_pkg::SIDE_BOTTOM; xs[n] = p; ys[n] = box_b; n++;
        end
        if (n < 2 && side_hit(sy, ey, sx, ex, box_t, 0, box_l, box_r, t, p)) begin
            ts[n] = t; sd[n] = sbc_pkg::SIDE_TOP; xs[n] = p; ys[n] = box_t; n++;
        end
        a = 0;
        b = 1;
        if (n == 2 && ts[0] > ts[1]) begin
            a = 1;
            b = 0;
        end
        res = '0;
        res.count = n[1:0];
        if (n >= 1) begin
            res.near_side = sd[a];
            res.near_x = xs[a][31:0];
            res.near_y = ys[a][31:0];
        end
        if (n == 2) begin
            res.far_side = sd[b];
            res.far_x = xs[b][31:0];
            res.far_y = ys[b][31:0];
        end
        return res;
    endfunction

    class crossing_board;
        t_crossing pending[$];

        function void note_segment(input logic signed [31:0] sx, sy, ex, ey);
            pending.push_back(predict_crossings(sx, sy, ex, ey));
        endfunction

        task check_result(input t_crossing got);
            t_crossing w;
            if (pending.size() == 0) begin
                report("unexpected result", got.count, 0);
                return;
            end
            w = pending.pop_front();
            if (got.count !== w.count) report("crossing_count", got.count, w.count);
            if (got.near_side !== w.near_side) report("near_side", got.near_side, w.near_side);
            if (got.near_x !== w.near_x) report("near_x", got.near_x, w.near_x);
            if (got.near_y !== w.near_y) report("near_y", got.near_y, w.near_y);
            if (got.far_side !== w.far_side) report("far_side", got.far_side, w.far_side);
            if (got.far_x !== w.far_x) report("far_x", got.far_x, w.far_x);
            if (got.far_y !== w.far_y) report("far_y", got.far_y, w.far_y);
        endtask
    endclass

    crossing_board board = new();

    initial begin
        seg_if.valid <= 1'b0;
        seg_if.start_x <= '0;
        seg_if.start_y <= '0;
        seg_if.end_x <= '0;
        seg_if.end_y <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.addr <= sbc_pkg::CFG_BOX_LEFT;
        cfg_if.data <= '0;
        res_if.ready <= 1'b0;
    end

    // Receiver: random stall bursts, none in the calm tail.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready)
                board.check_result('{res_if.crossing_count, res_if.near_side, res_if.near_x,
                                     res_if.near_y, res_if.far_side, res_if.far_x,
                                     res_if.far_y});
        end
    end

    initial begin
        int hold;
        @(posedge i_clk);
        forever begin
            if (!calm && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(1, 5);
                res_if.ready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end else begin
                res_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((seg_if.valid && seg_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic write_reg(input sbc_pkg::t_cfg_addr idx, input logic [31:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.addr <= idx;
        cfg_if.data <= value;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
        case (idx)
            sbc_pkg::CFG_BOX_LEFT:   box_l = longint'(signed'(value));
            sbc_pkg::CFG_BOX_RIGHT:  box_r = longint'(signed'(value));
            sbc_pkg::CFG_BOX_BOTTOM: box_b = longint'(signed'(value));
            sbc_pkg::CFG_BOX_TOP:    box_t = longint'(signed'(value));
            sbc_pkg::CFG_TOLERANCE:  tol = value[15:0];
            default: ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] l, r, b, t, input logic [15:0] e);
        write_reg(sbc_pkg::CFG_BOX_LEFT, l);
        write_reg(sbc_pkg::CFG_BOX_RIGHT, r);
        write_reg(sbc_pkg::CFG_BOX_BOTTOM, b);
        write_reg(sbc_pkg::CFG_BOX_TOP, t);
        write_reg(sbc_pkg::CFG_TOLERANCE, {16'd0, e});
    endtask

    task automatic send_segment(input logic [31:0] sx, sy, ex, ey);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            seg_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_if.valid <= 1'b1;
        seg_if.start_x <= sx;
        seg_if.start_y <= sy;
        seg_if.end_x <= ex;
        seg_if.end_y <= ey;
        @(posedge i_clk);
        while (!seg_if.ready) @(posedge i_clk);
        board.note_segment(sx, sy, ex, ey);
    endtask

    task automatic drain();
        seg_if.valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    // Coordinate near the box most of the time, any 32-bit value otherwise.
    function automatic logic [31:0] pick_coord(input longint lo, hi);
        longint span;
        if ($urandom_range(0, 9) == 0) return $urandom;
        span = hi - lo;
        if (span < 0) span = -span;
        span = span + 64;
        return 32'(lo - span + longint'($urandom_range(0, 32'(3 * span))));
    endfunction

    task automatic random_phase(input int n_items);
        logic [31:0] sx, sy, ex, ey;
        for (int i = 0; i < n_items; i++) begin
            sx = pick_coord(box_l, box_r);
            sy = pick_coord(box_b, box_t);
            ex = pick_coord(box_l, box_r);
            ey = pick_coord(box_b, box_t);
            case ($urandom_range(0, 7))
                0: ex = sx;
                1: ey = sy;
                2: ex = 32'(box_l);
                3: ey = 32'(box_t);
                default: ;
            endcase
            send_segment(sx, sy, ex, ey);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed, reset box first: through, tangent, axis-aligned, degenerate.
        send_segment(-32'sd65536, 32'sd32768, 32'sd131072, 32'sd32768);
        send_segment(32'sd131072, 32'sd32768, -32'sd65536, 32'sd32768);
        send_segment(32'sd32768, -32'sd65536, 32'sd32768, 32'sd131072);
        send_segment(-32'sd65536, -32'sd65536, 32'sd131072, 32'sd131072);
        send_segment(32'sd32768, 32'sd32768, 32'sd32768, 32'sd32768);
        send_segment(32'sd32768, 32'sd32768, 32'sd200000, 32'sd40000);
        send_segment(-32'sd65536, 32'sd200000, 32'sd131072, 32'sd200000);
        send_segment(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff);
        send_segment(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff);
        send_segment(32'hffffffff, 32'd0, 32'd65537, 32'd65536);
        send_segment(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
        drain();

        // Extreme box, zero tolerance.
        set_box(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 16'd0);
        send_segment(32'h80000000, 32'd0, 32'h7fffffff, 32'd5);
        send_segment(32'd0, 32'd0, 32'd100, 32'd100);
        send_segment(32'hffffffff, 32'hffffffff, 32'h00000001, 32'h00000001);
        drain();

        // Reversed box and maximal tolerance.
        set_box(32'sd65536, 32'sd0, 32'sd65536, 32'sd0, 16'hffff);
        send_segment(-32'sd65536, 32'sd32768, 32'sd131072, 32'sd32768);
        send_segment(-32'sd65536, -32'sd65536, 32'sd131072, 32'sd131072);
        random_phase(60);
        drain();
        // Out-of-range index must be ignored.
        write_reg(sbc_pkg::t_cfg_addr'(5), 32'hdeadbeef);
        write_reg(sbc_pkg::t_cfg_addr'(7), 32'h12345678);

        for (int ph = 0; ph < 6; ph++) begin
            longint c, h;
            c = $signed($urandom_range(0, 400000)) - 200000;
            h = $urandom_range(1, 300000);
            set_box(32'(c - h), 32'(c + h), 32'(c - h / 2), 32'(c + h),
                    16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 2000)));
            random_phase(80);
            drain();
        end

        set_box(32'sd0, 32'sd65536, 32'sd0, 32'sd65536, 16'd1);
        calm = 1'b1;
        random_phase(60);
        drain();

        if (n_errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
